// ----- rtl/core/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg
// shared types and constants of the postfix stack evaluator
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int unsigned DEPTH    = 32;
    localparam int unsigned AW       = $clog2(DEPTH);
    localparam int unsigned CW       = 6;

    localparam logic [7:0] SYM_END   = 8'd35;
    localparam logic [7:0] SYM_ADD   = 8'd43;
    localparam logic [7:0] SYM_SUB   = 8'd45;
    localparam logic [7:0] SYM_MUL   = 8'd42;
    localparam logic [7:0] SYM_DIV   = 8'd47;
    localparam logic [7:0] SYM_REM   = 8'd37;
    localparam logic [7:0] DIGIT_BASE = 8'd48;
    localparam logic [CW-1:0] CAPACITY_RESET = 6'd20;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_LEFT    = 3'd4;
    localparam logic [2:0] ST_FINAL   = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load_sym;  // capture symbol, decode
        logic rd_b;      // read top entry
        logic rd_a;      // read second entry
        logic rd_bot;    // read entry 0
        logic alu_go;    // latch operands, start arithmetic
        logic div_step;  // one divider iteration
        logic push_res;  // write alu result, report
        logic push_dig;  // write digit, report
        logic rep_err;   // report error
        logic chk_b;     // error found after popping the top entry
        logic rep_end;   // report end marker
    } pse_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_end;
        logic is_op;
        logic is_divop;
        logic halted;
        logic empty;      // count == 0
        logic one_left;   // count == 1
        logic full;       // count >= effective capacity
        logic b_zero;     // read data is zero
        logic div_done;
        logic out_busy;   // result register still holds a result
    } pse_stat_t;

endpackage

// ----- rtl/core/postfix_stack_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core
// postfix evaluator on a 32-bit integer stack, one symbol per transfer
// ----------------------------------------------------------------------------
// Each accepted symbol gives one result transfer. A digit push or an error
// found at decode is reported from decode, an error found after popping the
// right operand from the operand check, '#' from the end state, and '+' '-'
// '*' '/' '%' from the push state, '/' '%' after the 32-iteration restoring
// divider; the stack is a 32-entry memory with one registered read port,
// read once per popped operand. The next symbol is taken once the previous
// one has finished; a pending result holds the controller until it is taken.
module postfix_stack_evaluator_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [5:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_symbol,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_top_value,
    output logic [5:0]         m_left_count,
    output logic               m_last
);
    import pse_pkg::*;

    pse_cmd_t  cmd;
    pse_stat_t stat;

    pse_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .cmd(cmd), .stat(stat)
    );

    pse_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_symbol(s_symbol), .cmd(cmd), .stat(stat), .m_valid(m_valid),
        .m_ready(m_ready), .m_status(m_status), .m_top_value(m_top_value),
        .m_left_count(m_left_count), .m_last(m_last)
    );
endmodule

// ----- rtl/core/pse_datapath.sv -----
// ----------------------------------------------------------------------------
// pse_datapath
// stack memory, entry count, error latch, alu with iterative divider, result
// register
// ----------------------------------------------------------------------------
module pse_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [5:0]              cfg_data,
    input  logic [7:0]              s_symbol,
    input  pse_pkg::pse_cmd_t       cmd,
    output pse_pkg::pse_stat_t      stat,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [2:0]              m_status,
    output logic signed [31:0]      m_top_value,
    output logic [5:0]              m_left_count,
    output logic                    m_last
);
    import pse_pkg::*;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;
    logic [CW-1:0] cap_reg;
    logic [CW-1:0] cnt_reg;
    logic [1:0]    err_reg;
    logic [7:0]    sym_reg;
    logic [31:0]   b_reg, res_reg;
    logic [31:0]   dvd_reg, rem_reg;
    logic [5:0]    dcnt_reg;
    logic          neg_q_reg, neg_r_reg;
    logic          out_v_reg;
    logic [2:0]    o_st_reg;
    logic [31:0]   o_val_reg;
    logic [5:0]    o_left_reg;
    logic          o_last_reg;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] eff_cap;
    logic [32:0]   trial;
    logic [31:0]   mag_b;
    logic [31:0]   dig_val;

    assign eff_cap = (cap_reg < CW'(DEPTH)) ? cap_reg : CW'(DEPTH);
    assign mag_b   = b_reg[31] ? (32'd0 - b_reg) : b_reg;
    assign trial   = {rem_reg, dvd_reg[31]} - {1'b0, mag_b};
    assign dig_val = {24'd0, sym_reg} - {24'd0, DIGIT_BASE};

    always_comb begin
        rd_addr = AW'(cnt_reg - 6'd1);
        if (cmd.rd_bot) rd_addr = '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_b || cmd.rd_a || cmd.rd_bot) rdata_reg <= mem[rd_addr];
        if (cmd.push_res) mem[AW'(cnt_reg)] <= res_reg;
        else if (cmd.push_dig) mem[AW'(cnt_reg)] <= dig_val;
    end

    assign stat.is_end   = (sym_reg == SYM_END);
    assign stat.is_op    = (sym_reg == SYM_ADD) || (sym_reg == SYM_SUB) ||
                           (sym_reg == SYM_MUL) || (sym_reg == SYM_DIV) ||
                           (sym_reg == SYM_REM);
    assign stat.is_divop = (sym_reg == SYM_DIV) || (sym_reg == SYM_REM);
    assign stat.halted   = (err_reg != 2'd0);
    assign stat.empty    = (cnt_reg == 6'd0);
    assign stat.one_left = (cnt_reg == 6'd1);
    assign stat.full     = (cnt_reg >= eff_cap);
    assign stat.b_zero   = (rdata_reg == 32'd0);
    assign stat.div_done = (dcnt_reg == 6'd0);
    assign stat.out_busy = out_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAPACITY_RESET;
            cnt_reg   <= '0;
            err_reg   <= '0;
            out_v_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else begin
            if (cfg_we) cap_reg <= cfg_data;
            if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            if (cmd.load_sym) sym_reg <= s_symbol;
            if (cmd.rd_b) cnt_reg <= cnt_reg - 6'd1;
            if (cmd.rd_a) begin
                cnt_reg <= cnt_reg - 6'd1;
                b_reg   <= rdata_reg;
            end
            if (cmd.alu_go) begin
                neg_q_reg <= rdata_reg[31] ^ b_reg[31];
                neg_r_reg <= rdata_reg[31];
                dvd_reg   <= rdata_reg[31] ? (32'd0 - rdata_reg) : rdata_reg;
                rem_reg   <= '0;
                dcnt_reg  <= stat.is_divop ? 6'd32 : 6'd0;
                case (sym_reg)
                    SYM_ADD: res_reg <= rdata_reg + b_reg;
                    SYM_SUB: res_reg <= rdata_reg - b_reg;
                    SYM_MUL: res_reg <= rdata_reg * b_reg;
                    default: res_reg <= '0;
                endcase
            end
            if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg - 6'd1;
                if (!trial[32]) begin
                    rem_reg <= trial[31:0];
                    dvd_reg <= {dvd_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[30:0], dvd_reg[31]};
                    dvd_reg <= {dvd_reg[30:0], 1'b0};
                end
                if (dcnt_reg == 6'd1) begin
                    if (sym_reg == SYM_DIV) begin
                        res_reg <= neg_q_reg ? (32'd0 - {dvd_reg[30:0], ~trial[32]})
                                             : {dvd_reg[30:0], ~trial[32]};
                    end else begin
                        res_reg <= trial[32]
                            ? (neg_r_reg ? 32'd0 - {rem_reg[30:0], dvd_reg[31]}
                                         : {rem_reg[30:0], dvd_reg[31]})
                            : (neg_r_reg ? 32'd0 - trial[31:0] : trial[31:0]);
                    end
                end
            end
            if (cmd.push_res) begin
                cnt_reg    <= cnt_reg + 6'd1;
                out_v_reg  <= 1'b1;
                o_st_reg   <= ST_OK;
                o_val_reg  <= res_reg;
                o_left_reg <= '0;
                o_last_reg <= 1'b0;
            end
            if (cmd.push_dig) begin
                cnt_reg    <= cnt_reg + 6'd1;
                out_v_reg  <= 1'b1;
                o_st_reg   <= ST_OK;
                o_val_reg  <= dig_val;
                o_left_reg <= '0;
                o_last_reg <= 1'b0;
            end
            if (cmd.rep_err) begin
                logic [1:0] e;
                e = err_reg;
                if (!stat.halted) begin
                    if (!stat.is_op) e = ST_FULL[1:0];
                    else if (cmd.chk_b && stat.is_divop && stat.b_zero)
                        e = ST_DIVZERO[1:0];
                    else e = ST_EMPTY[1:0];
                end
                err_reg    <= e;
                out_v_reg  <= 1'b1;
                o_st_reg   <= {1'b0, e};
                o_val_reg  <= '0;
                o_left_reg <= '0;
                o_last_reg <= 1'b0;
            end
            if (cmd.rep_end) begin
                out_v_reg  <= 1'b1;
                o_last_reg <= 1'b1;
                o_val_reg  <= '0;
                o_left_reg <= '0;
                if (stat.halted) o_st_reg <= {1'b0, err_reg};
                else if (stat.one_left) begin
                    o_st_reg  <= ST_FINAL;
                    o_val_reg <= rdata_reg;
                end else begin
                    o_st_reg   <= ST_LEFT;
                    o_left_reg <= cnt_reg;
                end
                cnt_reg <= '0;
                err_reg <= '0;
            end
        end
    end

    assign m_valid      = out_v_reg;
    assign m_status     = o_st_reg;
    assign m_top_value  = o_val_reg;
    assign m_left_count = o_left_reg;
    assign m_last       = o_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_dig |-> !stat.full)
        else $error("digit push past capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push_res || cmd.push_dig || cmd.rep_err || cmd.rep_end) |-> !out_v_reg)
        else $error("result overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> dcnt_reg != 6'd0)
        else $error("divider stepped past end");
endmodule

// ----- rtl/core/pse_ctrl.sv -----
// ----------------------------------------------------------------------------
// pse_ctrl
// sequencer for one symbol: decode, stack reads, arithmetic, report
// ----------------------------------------------------------------------------
module pse_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output pse_pkg::pse_cmd_t    cmd,
    input  pse_pkg::pse_stat_t   stat
);
    import pse_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DEC  = 9'b000000010,
        S_RDB  = 9'b000000100,
        S_CHKB = 9'b000001000,
        S_RDA  = 9'b000010000,
        S_ALU  = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_PUSH = 9'b010000000,
        S_END  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_sym = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (stat.is_end) begin
                    cmd.rd_bot = 1'b1;
                    state_next = S_END;
                end else if (!stat.out_busy) begin
                    if (stat.halted || (stat.is_op && stat.empty) ||
                        (!stat.is_op && stat.full)) begin
                        cmd.rep_err = 1'b1;
                        state_next = S_IDLE;
                    end else if (stat.is_op) begin
                        cmd.rd_b = 1'b1;
                        state_next = S_CHKB;
                    end else begin
                        cmd.push_dig = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_CHKB: begin
                if ((stat.is_divop && stat.b_zero) || stat.empty) begin
                    cmd.rep_err = 1'b1;
                    cmd.chk_b = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cmd.rd_a = 1'b1;
                    state_next = S_RDA;
                end
            end
            S_RDA: begin
                cmd.alu_go = 1'b1;
                state_next = stat.is_divop ? S_DIV : S_PUSH;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    cmd.div_step = 1'b0;
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                cmd.push_res = 1'b1;
                state_next = S_IDLE;
            end
            S_END: begin
                if (!stat.out_busy) begin
                    cmd.rep_end = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RDB: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the postfix stack evaluator core: a directed table
// of symbols, then random expressions, checked against a behavioral stack
// model, with sender and receiver idling in three phases
// ----------------------------------------------------------------------------
module tb_top;
    import pse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]         status;
        logic signed [31:0] top_value;
        logic [5:0]         left_count;
        logic               last;
    } eval_res_t;

    typedef struct {
        logic [7:0] sym;
        logic       has_res;
        eval_res_t  res;
    } dir_row_t;

    localparam longint CYCLE_LIMIT = 2000000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [5:0]         cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_symbol = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_status;
    logic signed [31:0] m_top_value;
    logic [5:0]         m_left_count;
    logic               m_last;

    // behavioral stack state
    logic [31:0] stk [DEPTH];
    int          stk_cnt;
    logic [2:0]  err_latched;
    logic [5:0]  cap_reg;

    eval_res_t expected_q[$];
    int        err_count;
    longint    cycle_cnt;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        emitted;

    postfix_stack_evaluator_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_symbol    (s_symbol),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_top_value (m_top_value),
        .m_left_count(m_left_count),
        .m_last      (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] mag(logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic eval_res_t stack_step(logic [7:0] sym);
        eval_res_t  r;
        logic [31:0] a, b, q, res;
        int          eff;
        r = '{ST_OK, 0, 0, 1'b0};
        eff = (cap_reg < DEPTH) ? cap_reg : DEPTH;
        if (sym == SYM_END) begin
            r.last = 1'b1;
            if (err_latched != ST_OK) r.status = err_latched;
            else if (stk_cnt == 1) begin
                r.status = ST_FINAL;
                r.top_value = stk[0];
            end else begin
                r.status = ST_LEFT;
                r.left_count = stk_cnt[5:0];
            end
            stk_cnt = 0;
            err_latched = ST_OK;
            return r;
        end
        if (err_latched != ST_OK) begin
            r.status = err_latched;
            return r;
        end
        if (sym inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_REM}) begin
            if (stk_cnt == 0) err_latched = ST_EMPTY;
            else begin
                stk_cnt--;
                b = stk[stk_cnt];
                if ((sym == SYM_DIV || sym == SYM_REM) && b == 0) err_latched = ST_DIVZERO;
                else if (stk_cnt == 0) err_latched = ST_EMPTY;
                else begin
                    stk_cnt--;
                    a = stk[stk_cnt];
                    case (sym)
                        SYM_ADD: res = a + b;
                        SYM_SUB: res = a - b;
                        SYM_MUL: res = a * b;
                        SYM_DIV: begin
                            q = mag(a) / mag(b);
                            res = (a[31] != b[31]) ? 32'd0 - q : q;
                        end
                        default: begin
                            q = mag(a) % mag(b);
                            res = a[31] ? 32'd0 - q : q;
                        end
                    endcase
                    stk[stk_cnt] = res;
                    stk_cnt++;
                end
            end
        end else begin
            if (stk_cnt >= eff) err_latched = ST_FULL;
            else begin
                stk[stk_cnt] = {24'd0, sym} - 32'd48;
                stk_cnt++;
            end
        end
        if (err_latched != ST_OK) r.status = err_latched;
        else r.top_value = stk[stk_cnt - 1];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
        err_count++;
    endtask

    // result checker and receiver idling
    always @(posedge aclk) begin
        eval_res_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transfer", m_status, -1);
                end else begin
                    e = expected_q.pop_front();
                    if (m_status !== e.status) report_mismatch("status", m_status, e.status);
                    if (m_top_value !== e.top_value)
                        report_mismatch("top_value", m_top_value, e.top_value);
                    if (m_left_count !== e.left_count)
                        report_mismatch("left_count", m_left_count, e.left_count);
                    if (m_last !== e.last) report_mismatch("last", m_last, e.last);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_symbol(logic [7:0] sym, logic has_res, eval_res_t want);
        eval_res_t p;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_symbol <= sym;
        do @(posedge aclk); while (!s_ready);
        p = stack_step(sym);
        if (has_res && (p.status !== want.status || p.top_value !== want.top_value ||
                        p.left_count !== want.left_count || p.last !== want.last))
            report_mismatch("table row vs model", sym, p.status);
        expected_q.push_back(has_res ? want : p);
        emitted++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [5:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cap_reg = v;
    endtask

    // random symbol: mostly digits and operators, sometimes other bytes or '#'
    function automatic logic [7:0] rand_symbol(int depth_now);
        int k;
        logic [7:0] ops[5] = '{SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_REM};
        k = $urandom_range(99);
        if (k < 3) return SYM_END;
        if (k < 8) return 8'($urandom_range(255));
        if (depth_now >= 2 && k < 55) return ops[$urandom_range(4)];
        if (k < 12) return ops[$urandom_range(4)];
        return 8'($urandom_range(57, 48));
    endfunction

    task automatic random_expression();
        int n, d;
        logic [7:0] s;
        n = $urandom_range(25, 2);
        d = 0;
        for (int i = 0; i < n; i++) begin
            s = rand_symbol(d);
            if (s == SYM_END) d = 0;
            else if (s inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_REM}) d = (d > 0) ? d - 1 : 0;
            else d++;
            send_symbol(s, 1'b0, '{ST_OK, 0, 0, 1'b0});
        end
        send_symbol(SYM_END, 1'b0, '{ST_OK, 0, 0, 1'b0});
    endtask

    dir_row_t dir_tbl[] = '{
        '{SYM_END, 1, '{ST_LEFT, 0, 0, 1'b1}},
        '{SYM_ADD, 1, '{ST_EMPTY, 0, 0, 1'b0}},
        '{8'h35,   1, '{ST_EMPTY, 0, 0, 1'b0}},
        '{SYM_END, 1, '{ST_EMPTY, 0, 0, 1'b1}},
        '{8'h39,   1, '{ST_OK, 9, 0, 1'b0}},
        '{SYM_MUL, 1, '{ST_EMPTY, 0, 0, 1'b0}},
        '{SYM_END, 1, '{ST_EMPTY, 0, 0, 1'b1}},
        '{8'h00,   1, '{ST_OK, -48, 0, 1'b0}},
        '{8'hFF,   1, '{ST_OK, 207, 0, 1'b0}},
        '{SYM_MUL, 0, '{ST_OK, 0, 0, 1'b0}},
        '{8'h37,   0, '{ST_OK, 0, 0, 1'b0}},
        '{SYM_REM, 0, '{ST_OK, 0, 0, 1'b0}},
        '{8'h33,   0, '{ST_OK, 0, 0, 1'b0}},
        '{SYM_SUB, 0, '{ST_OK, 0, 0, 1'b0}},
        '{8'h34,   0, '{ST_OK, 0, 0, 1'b0}},
        '{SYM_DIV, 0, '{ST_OK, 0, 0, 1'b0}},
        '{8'h32,   0, '{ST_OK, 0, 0, 1'b0}},
        '{SYM_ADD, 0, '{ST_OK, 0, 0, 1'b0}},
        '{SYM_END, 0, '{ST_OK, 0, 0, 1'b0}},
        '{8'h36,   1, '{ST_OK, 6, 0, 1'b0}},
        '{8'h30,   1, '{ST_OK, 0, 0, 1'b0}},
        '{SYM_DIV, 1, '{ST_DIVZERO, 0, 0, 1'b0}},
        '{8'h31,   1, '{ST_DIVZERO, 0, 0, 1'b0}},
        '{SYM_END, 1, '{ST_DIVZERO, 0, 0, 1'b1}},
        '{8'h30,   1, '{ST_OK, 0, 0, 1'b0}},
        '{SYM_REM, 1, '{ST_DIVZERO, 0, 0, 1'b0}},
        '{SYM_END, 1, '{ST_DIVZERO, 0, 0, 1'b1}}
    };

    // build INT_MIN on the stack: (0-8)*(2^28) via repeated multiplies
    task automatic int_min_case(logic [7:0] op);
        logic [7:0] seq[$];
        seq = '{8'h30, 8'h38, SYM_SUB};
        repeat (7) seq = {seq, 8'h40, SYM_MUL};   // 8'h40 pushes 16
        seq = {seq, 8'h30, 8'h31, SYM_SUB, op, SYM_END};
        foreach (seq[i]) send_symbol(seq[i], 1'b0, '{ST_OK, 0, 0, 1'b0});
    endtask

    initial begin
        int phase_items;
        eval_res_t none;
        none = '{ST_OK, 0, 0, 1'b0};
        err_count = 0;
        cycle_cnt = 0;
        emitted = 0;
        stk_cnt = 0;
        err_latched = ST_OK;
        cap_reg = CAPACITY_RESET;
        send_idle_pct = 12;
        recv_idle_pct = 73;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tbl[i]) send_symbol(dir_tbl[i].sym, dir_tbl[i].has_res, dir_tbl[i].res);
        send_symbol(SYM_END, 1'b0, none);
        int_min_case(SYM_DIV);
        int_min_case(SYM_REM);
        drain();

        // capacity extremes: 1 full, 0 always full, 63 clamps to depth
        write_capacity(6'd1);
        send_symbol(8'h31, 1'b1, '{ST_OK, 1, 0, 1'b0});
        send_symbol(8'h32, 1'b1, '{ST_FULL, 0, 0, 1'b0});
        send_symbol(SYM_END, 1'b1, '{ST_FULL, 0, 0, 1'b1});
        drain();
        write_capacity(6'd0);
        send_symbol(8'h31, 1'b1, '{ST_FULL, 0, 0, 1'b0});
        send_symbol(SYM_END, 1'b1, '{ST_FULL, 0, 0, 1'b1});
        drain();
        write_capacity(6'd63);
        repeat (33) send_symbol(8'($urandom_range(255)) | 8'h80, 1'b0, none);
        send_symbol(SYM_END, 1'b0, none);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 73 : 0;
            recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 12 : 0;
            write_capacity((ph == 0) ? 6'd32 : (ph == 1) ? 6'd4 : 6'($urandom_range(63)));
            phase_items = emitted + 360;
            while (emitted < phase_items) random_expression();
            drain();
        end

        if (err_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
